// ===== rtl/core/gaussian_blur_3x3_rgb_defines.svh =====
// Assertion macros shared by the blur core.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define GB3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define GB3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gb3_pkg.sv =====
// Shared types and constants of the 3x3 blur core.
// No dependencies; imported by the line bank, the kernel and the top level.
package gb3_pkg;

    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int WORD_W      = PIX_W * LANES;
    localparam int FW_W        = 11;
    localparam int FH_W        = 12;
    localparam int ROW_W       = 12;
    localparam int ROWX_W      = ROW_W + 1;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;
    localparam int VSUM_W      = CH_W + 2;
    localparam int HSUM_W      = VSUM_W + 2;
    localparam int NORM_SHIFT  = 4;
    localparam int OFIFO_DEPTH = 4;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } t_kind;

    // Control of one window read, from the sequencer to the kernel
    typedef struct packed {
        logic              emit;
        logic              last;
        logic              center_odd;
        logic [LANE_W-1:0] up_lane;
        logic [LANE_W-1:0] mid_lane;
        logic [LANE_W-1:0] dn_lane;
        logic              left_is_c;
        logic              right_is_c;
        logic              fwd_l;
        logic              fwd_c;
        logic              fwd_r;
        logic [LANE_W-1:0] wr_lane;
        logic [PIX_W-1:0]  wr_pix;
    } t_kern_ctl;

endpackage

// ===== rtl/core/gaussian_blur_3x3_rgb.sv =====
// 3x3 Gaussian blur (1-2-1 by 1-2-1, divided by 16 with truncation) of a BGR stream
// in raster order, edges replicated; built on gb3_pkg, gb3_line_bank and gb3_kernel.
// The block takes one word per clock, pixel or drain tick, for as long as the output
// side keeps up; each result passes the read stage and the kernel's sum register. The
// rate is set by the line memory: two banks split by column parity, each word holding
// one column of the four most recent rows, each bank with two read ports, so all nine
// window taps are fetched in the same cycle as the incoming pixel is written. A 4-deep
// output FIFO decouples the two sides; the slave side stalls only once the FIFO and
// the two pipeline stages in front of it hold four words between them.
// An output pixel leaves once its lower-right neighbour (clamped) has arrived; the
// outputs still pending after a frame's last pixel, at most one row and one pixel,
// are emitted by drain ticks, one pixel per tick, and the next frame is taken after
// the frame's last output (tlast). The line memory has no reset and needs no clearing
// pass. Frame size registers must be written while idle; the block does not enforce it.
module gaussian_blur_3x3_rgb
    import gb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [PIX_W-1:0]      i_s_axis_tdata,   // blue_in [7:0], green_in [15:8], red_in [23:16]
    input  logic                  i_s_axis_tuser,   // kind [0]
    // output words
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [PIX_W-1:0]      o_m_axis_tdata,   // blue_out [7:0], green_out [15:8], red_out [23:16]
    output logic                  o_m_axis_tlast    // frame_end
);

    `include "gaussian_blur_3x3_rgb_defines.svh"

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW    = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int HD    = (MAX_WIDTH + 1) / 2;
    localparam int AW    = (HD > 1) ? $clog2(HD) : 1;
    localparam int FP_W  = $clog2(OFIFO_DEPTH);
    localparam int FC_W  = $clog2(OFIFO_DEPTH + 1);
    localparam int CRD_W = FC_W + 1;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pix;
    } t_out_word;

    // configuration and position registers
    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [CW-1:0]     r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [CW-1:0]     r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [CW-1:0]     n_in_col;
    logic [ROW_W-1:0]  n_in_row;
    logic [CW-1:0]     n_out_col;
    logic [ROW_W-1:0]  n_out_row;

    logic [XW-1:0]     w_eff;
    logic [ROWX_W-1:0] h_eff;
    logic              w_is_pixel;
    logic              w_accept;
    logic              w_emit;

    // sequencer temporaries
    logic [XW-1:0]     w_ic;
    logic [ROWX_W-1:0] w_ir;
    logic [XW-1:0]     w_oc;
    logic [ROWX_W-1:0] w_or;
    logic [XW-1:0]     w_oc_nx;
    logic              w_wr_en;
    logic [XW-1:0]     w_wr_col;
    logic [LANE_W-1:0] w_wr_lane;
    logic [ROWX_W-1:0] w_need_r;
    logic [XW-1:0]     w_need_c;
    logic              w_ready;
    logic              w_last;

    // read side
    logic [ROWX_W-1:0] w_or_m1;
    logic [XW-1:0]     w_c_m1;
    logic [XW-1:0]     w_c_p1;
    logic [AW-1:0]     w_addr_c;
    logic [AW-1:0]     w_addr_m;
    logic [AW-1:0]     w_addr_p;
    logic [AW-1:0]     w_waddr;
    t_kern_ctl         n_s1_ctl;
    t_kern_ctl         r_s1_ctl;

    logic [WORD_W-1:0] w_b0_a;
    logic [WORD_W-1:0] w_b0_b;
    logic [WORD_W-1:0] w_b1_a;
    logic [WORD_W-1:0] w_b1_b;

    logic              w_kern_valid;
    logic              w_kern_last;
    logic [PIX_W-1:0]  w_kern_pix;

    // output FIFO
    t_out_word         r_fifo [OFIFO_DEPTH];
    logic [FP_W-1:0]   r_wr_ptr;
    logic [FP_W-1:0]   r_rd_ptr;
    logic [FC_W-1:0]   r_cnt;
    logic              w_push;
    logic              w_pop;
    logic [CRD_W-1:0]  w_credit;

    // Clamp the frame size registers to usable values
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = XW'(1);
        end else if (XW'(r_frame_width) > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? ROWX_W'(1) : ROWX_W'(r_frame_height);
    end

    assign w_is_pixel = (t_kind'(i_s_axis_tuser) == KIND_PIXEL);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_emit     = w_accept && w_ready;

    // Advance input and output positions for one word
    always_comb begin
        w_ic = XW'(r_in_col);
        w_ir = ROWX_W'(r_in_row);
        w_oc = XW'(r_out_col);
        w_or = ROWX_W'(r_out_row);
        // wrap positions left past the row end by a width change
        if (w_ic >= w_eff) begin
            w_ic = '0;
            w_ir = w_ir + 1'b1;
        end
        if (w_oc >= w_eff) begin
            w_oc = '0;
            w_or = w_or + 1'b1;
        end
        // restart the frame when the output or input position ran off its end
        if (w_or >= h_eff || w_ir > h_eff) begin
            w_ic = '0;
            w_ir = '0;
            w_oc = '0;
            w_or = '0;
        end
        // store the pixel unless the frame's input is complete
        w_wr_en   = w_is_pixel && (w_ir < h_eff);
        w_wr_col  = w_ic;
        w_wr_lane = w_ir[LANE_W-1:0];
        if (w_wr_en) begin
            w_ic = w_ic + 1'b1;
            if (w_ic >= w_eff) begin
                w_ic = '0;
                w_ir = w_ir + 1'b1;
            end
        end
        // output is ready once its clamped lower-right neighbour is in
        w_need_r = (w_or + 1'b1 < h_eff) ? w_or + 1'b1 : h_eff - 1'b1;
        w_need_c = (w_oc + 1'b1 < w_eff) ? w_oc + 1'b1 : w_eff - 1'b1;
        w_ready  = (w_need_r < w_ir) || (w_need_r == w_ir && w_need_c < w_ic);
        w_last   = (w_or == h_eff - 1'b1) && (w_oc == w_eff - 1'b1);
        w_oc_nx  = w_oc + 1'b1;

        n_in_col  = CW'(w_ic);
        n_in_row  = ROW_W'(w_ir);
        n_out_col = CW'(w_oc);
        n_out_row = ROW_W'(w_or);
        if (w_ready) begin
            if (w_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (w_oc_nx >= w_eff) begin
                n_out_col = '0;
                n_out_row = ROW_W'(w_or + 1'b1);
            end else begin
                n_out_col = CW'(w_oc_nx);
            end
        end
    end

    // Window addresses, row lanes, edge replication and same-cycle forwarding
    always_comb begin
        w_or_m1  = w_or - 1'b1;
        w_c_m1   = w_oc - 1'b1;
        w_c_p1   = w_oc + 1'b1;
        w_addr_c = AW'(w_oc >> 1);
        w_addr_m = AW'(w_c_m1 >> 1);
        w_addr_p = AW'(w_c_p1 >> 1);
        w_waddr  = AW'(w_wr_col >> 1);

        n_s1_ctl.emit       = w_emit;
        n_s1_ctl.last       = w_last;
        n_s1_ctl.center_odd = w_oc[0];
        n_s1_ctl.up_lane    = (w_or == '0) ? LANE_W'(0) : w_or_m1[LANE_W-1:0];
        n_s1_ctl.mid_lane   = w_or[LANE_W-1:0];
        n_s1_ctl.dn_lane    = w_need_r[LANE_W-1:0];
        n_s1_ctl.left_is_c  = (w_oc == '0);
        n_s1_ctl.right_is_c = (w_need_c == w_oc);
        n_s1_ctl.fwd_l      = w_accept && w_wr_en && (w_wr_col == w_c_m1);
        n_s1_ctl.fwd_c      = w_accept && w_wr_en && (w_wr_col == w_oc);
        n_s1_ctl.fwd_r      = w_accept && w_wr_en && (w_wr_col == w_c_p1);
        n_s1_ctl.wr_lane    = w_wr_lane;
        n_s1_ctl.wr_pix     = i_s_axis_tdata;
    end

    // Even columns: center or the two odd neighbours' partner
    gb3_line_bank #(
        .DEPTH(HD)
    ) u_bank_even (
        .i_clk     (i_clk),
        .i_we      (w_accept && w_wr_en && !w_wr_col[0]),
        .i_waddr   (w_waddr),
        .i_wlane   (w_wr_lane),
        .i_wpix    (i_s_axis_tdata),
        .i_raddr_a (w_oc[0] ? w_addr_m : w_addr_c),
        .i_raddr_b (w_addr_p),
        .o_rdata_a (w_b0_a),
        .o_rdata_b (w_b0_b)
    );

    // Odd columns
    gb3_line_bank #(
        .DEPTH(HD)
    ) u_bank_odd (
        .i_clk     (i_clk),
        .i_we      (w_accept && w_wr_en && w_wr_col[0]),
        .i_waddr   (w_waddr),
        .i_wlane   (w_wr_lane),
        .i_wpix    (i_s_axis_tdata),
        .i_raddr_a (w_oc[0] ? w_addr_c : w_addr_m),
        .i_raddr_b (w_addr_p),
        .o_rdata_a (w_b1_a),
        .o_rdata_b (w_b1_b)
    );

    gb3_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s1_ctl),
        .i_b0_a  (w_b0_a),
        .i_b0_b  (w_b0_b),
        .i_b1_a  (w_b1_a),
        .i_b1_b  (w_b1_b),
        .o_valid (w_kern_valid),
        .o_last  (w_kern_last),
        .o_pix   (w_kern_pix)
    );

    // Configuration, positions and the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_s1_ctl       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[FW_W-1:0];
                    end
                    REG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[FH_W-1:0];
                    end
                endcase
            end
            if (w_accept) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
            r_s1_ctl <= n_s1_ctl;
        end
    end

    // Admit a word only if its result is sure of a FIFO slot
    assign w_credit = CRD_W'(r_cnt) + CRD_W'(r_s1_ctl.emit) + CRD_W'(w_kern_valid);
    assign o_s_axis_tready = (w_credit < CRD_W'(OFIFO_DEPTH));

    assign w_push = w_kern_valid;
    assign w_pop  = o_m_axis_tvalid && i_m_axis_tready;

    // Output FIFO pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == FP_W'(OFIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == FP_W'(OFIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Output FIFO storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= '{last: w_kern_last, pix: w_kern_pix};
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_fifo[r_rd_ptr].pix;
    assign o_m_axis_tlast  = r_fifo[r_rd_ptr].last;

    `GB3_ASSERT_IMP(a_fifo_no_overflow, w_push && !w_pop, r_cnt < FC_W'(OFIFO_DEPTH),
        "output FIFO overflow")
    `GB3_ASSERT_IMP(a_credit_bound, 1'b1, w_credit <= CRD_W'(OFIFO_DEPTH),
        "words in flight exceed FIFO room")
    `GB3_ASSERT_IMP(a_emit_reaches_fifo, w_emit, ##2 w_push,
        "released pixel did not reach the FIFO")
    `GB3_ASSERT_NXT(a_frame_end_clears, w_emit && w_last,
        r_out_col == '0 && r_out_row == '0 && r_in_col == '0 && r_in_row == '0,
        "frame end did not restart positions")

endmodule

// ===== rtl/core/gb3_line_bank.sv =====
// One bank of the line memory: each word holds one column of four rows.
// Uses gb3_pkg; one lane write port, two registered read ports.
module gb3_line_bank
    import gb3_pkg::*;
#(
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [LANE_W-1:0] i_wlane,
    input  logic [PIX_W-1:0]  i_wpix,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [WORD_W-1:0] o_rdata_a,
    output logic [WORD_W-1:0] o_rdata_b
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata_a;
    logic [WORD_W-1:0] r_rdata_b;

    // Write one row lane, read two columns (old data on a same-cycle hit)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][i_wlane*PIX_W +: PIX_W] <= i_wpix;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/core/gb3_kernel.sv =====
// Window assembly and 1-2-1 weighting of the blur core.
// Uses gb3_pkg; takes the raw bank words plus control.
module gb3_kernel
    import gb3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_kern_ctl         i_ctl,
    input  logic [WORD_W-1:0] i_b0_a,
    input  logic [WORD_W-1:0] i_b0_b,
    input  logic [WORD_W-1:0] i_b1_a,
    input  logic [WORD_W-1:0] i_b1_b,
    output logic              o_valid,
    output logic              o_last,
    output logic [PIX_W-1:0]  o_pix
);

    function automatic logic [PIX_W-1:0] lane_pix(input logic [WORD_W-1:0] word,
                                                  input logic [LANE_W-1:0] lane);
        lane_pix = word[lane*PIX_W +: PIX_W];
    endfunction

    function automatic logic [WORD_W-1:0] put_lane(input logic [WORD_W-1:0] word,
                                                   input logic [LANE_W-1:0] lane,
                                                   input logic [PIX_W-1:0]  pix);
        logic [WORD_W-1:0] res;
        res = word;
        res[lane*PIX_W +: PIX_W] = pix;
        put_lane = res;
    endfunction

    logic [WORD_W-1:0] w_word_l;
    logic [WORD_W-1:0] w_word_c;
    logic [WORD_W-1:0] w_word_r;
    logic [WORD_W-1:0] w_col [3];
    logic [PIX_W-1:0]  w_tap [3][3];
    logic [VSUM_W-1:0] n_vs [3][3];
    logic [VSUM_W-1:0] r_vs [3][3];
    logic [HSUM_W-1:0] w_hs [3];
    logic              r_valid;
    logic              r_last;

    // Pick columns from the banks, patch in a pixel written in the same cycle
    always_comb begin
        w_word_c = i_ctl.center_odd ? i_b1_a : i_b0_a;
        w_word_l = i_ctl.center_odd ? i_b0_a : i_b1_a;
        w_word_r = i_ctl.center_odd ? i_b0_b : i_b1_b;
        if (i_ctl.fwd_c) begin
            w_word_c = put_lane(w_word_c, i_ctl.wr_lane, i_ctl.wr_pix);
        end
        if (i_ctl.fwd_l) begin
            w_word_l = put_lane(w_word_l, i_ctl.wr_lane, i_ctl.wr_pix);
        end
        if (i_ctl.fwd_r) begin
            w_word_r = put_lane(w_word_r, i_ctl.wr_lane, i_ctl.wr_pix);
        end
        // replicate the center column at the left and right frame edges
        w_col[0] = i_ctl.left_is_c  ? w_word_c : w_word_l;
        w_col[1] = w_word_c;
        w_col[2] = i_ctl.right_is_c ? w_word_c : w_word_r;
    end

    // Vertical 1-2-1 sums per column and channel
    always_comb begin
        for (int col = 0; col < 3; col++) begin
            w_tap[col][0] = lane_pix(w_col[col], i_ctl.up_lane);
            w_tap[col][1] = lane_pix(w_col[col], i_ctl.mid_lane);
            w_tap[col][2] = lane_pix(w_col[col], i_ctl.dn_lane);
            for (int ch = 0; ch < 3; ch++) begin
                n_vs[col][ch] = VSUM_W'(w_tap[col][0][ch*CH_W +: CH_W])
                              + VSUM_W'({w_tap[col][1][ch*CH_W +: CH_W], 1'b0})
                              + VSUM_W'(w_tap[col][2][ch*CH_W +: CH_W]);
            end
        end
    end

    // Hold stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
            r_last  <= i_ctl.last;
        end
    end

    // Hold column sums
    always_ff @(posedge i_clk) begin
        r_vs <= n_vs;
    end

    // Horizontal 1-2-1 sum, then divide by 16
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_hs[ch] = HSUM_W'(r_vs[0][ch]) + HSUM_W'({r_vs[1][ch], 1'b0})
                     + HSUM_W'(r_vs[2][ch]);
            o_pix[ch*CH_W +: CH_W] = w_hs[ch][NORM_SHIFT +: CH_W];
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for gaussian_blur_3x3_rgb: streams BGR frames in raster order and
// checks each filtered word against an in-bench 3x3 blur with edge replication.
// Depends on gb3_pkg and the RTL of the blur core only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gb3_pkg::*;

    localparam int LINE_MAX    = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 300;
    localparam int SETTLE      = 16;
    localparam int RANDOM_WORDS = 500;
    localparam int MAX_REPORTS = 40;

    // One filtered pixel; channels packed as on tdata, red on top
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_blur_pix;

    // Where the result of a word comes from
    typedef enum {CHECK_MODEL, CHECK_TYPED, CHECK_SILENT} t_word_check;
    typedef enum {ROW_CFG, ROW_WORD} t_row_op;

    typedef struct {
        t_row_op     op;
        logic [11:0] width_val;
        logic [11:0] height_val;
        t_kind       kind;
        logic [23:0] pix;
        t_word_check check;
        logic [23:0] res_pix;
        logic        res_last;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [PIX_W-1:0]      i_s_axis_tdata = '0;   // blue [7:0], green [15:8], red [23:16]
    logic                  i_s_axis_tuser = 1'b0; // kind [0]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      o_m_axis_tdata;        // blue [7:0], green [15:8], red [23:16]
    logic                  o_m_axis_tlast;        // frame_end

    gaussian_blur_3x3_rgb #(.MAX_WIDTH(LINE_MAX)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Blur state mirrored in the bench
    logic [10:0] size_w = 11'd640;
    logic [11:0] size_h = 12'd480;
    logic [23:0] line_mem [4][LINE_MAX];
    int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

    t_blur_pix   pending_pix [$];
    int unsigned useful_words = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;

    // Side info for the word currently on the input bus
    t_word_check word_check = CHECK_MODEL;
    t_blur_pix   word_res = '0;

    function automatic int unsigned eff_width();
        if (size_w == 0) return 1;
        if (size_w > LINE_MAX) return LINE_MAX;
        return size_w;
    endfunction

    function automatic int unsigned eff_height();
        return (size_h == 0) ? 1 : size_h;
    endfunction

    function automatic bit frame_open();
        return in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0;
    endfunction

    function automatic void clear_position();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Advance the mirrored blur by one word; return the output pixel it releases
    task automatic gauss_pixel_calc(input t_kind kind, input logic [23:0] pix,
                                    output bit emit, output t_blur_pix res,
                                    output bit dropped);
        int unsigned w, h, need_r, need_c, ry, cx, wt;
        int          v;
        int unsigned sum [3];
        w = eff_width();
        h = eff_height();
        emit = 1'b0;
        res = '0;
        dropped = 1'b0;
        sum = '{0, 0, 0};
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= h || in_row > h) clear_position();

        // Store the pixel; pixels past the frame's last input are dropped
        if (kind == KIND_PIXEL) begin
            if (in_row < h) begin
                line_mem[in_row % 4][in_col] = pix;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
            end else begin
                dropped = 1'b1;
            end
        end

        // Release the next output once its clamped lower-right neighbor is in
        need_r = (out_row + 1 < h) ? out_row + 1 : h - 1;
        need_c = (out_col + 1 < w) ? out_col + 1 : w - 1;
        if (!(need_r < in_row || (need_r == in_row && need_c < in_col))) return;
        emit = 1'b1;

        for (int dy = -1; dy <= 1; dy++) begin
            v = int'(out_row) + dy;
            ry = (v < 0) ? 0 : (v >= int'(h)) ? h - 1 : v;
            for (int dx = -1; dx <= 1; dx++) begin
                v = int'(out_col) + dx;
                cx = (v < 0) ? 0 : (v >= int'(w)) ? w - 1 : v;
                wt = (dy == 0 ? 2 : 1) * (dx == 0 ? 2 : 1);
                for (int ch = 0; ch < 3; ch++)
                    sum[ch] += wt * line_mem[ry % 4][cx][8*ch +: 8];
            end
        end
        res.blue  = 8'(sum[0] >> 4);
        res.green = 8'(sum[1] >> 4);
        res.red   = 8'(sum[2] >> 4);

        if (out_row == h - 1 && out_col == w - 1) begin
            res.frame_end = 1'b1;
            clear_position();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // Predict on every accepted input word
    always @(posedge i_clk) begin : in_watch
        bit        emit, dropped;
        t_blur_pix res;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            gauss_pixel_calc(t_kind'(i_s_axis_tuser), i_s_axis_tdata, emit, res, dropped);
            if (!dropped) useful_words++;
            case (word_check)
                CHECK_TYPED:  pending_pix.push_back(word_res);
                CHECK_SILENT: ;
                default:      if (emit) pending_pix.push_back(res);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %02h, actual %02h",
                         $time, name, want, got);
        end
    endtask

    // Compare each accepted output word with the oldest prediction
    always @(posedge i_clk) begin : out_watch
        t_blur_pix want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_pix.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected output word, expected none, actual %06h last %0b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                want = pending_pix.pop_front();
                check_field("blue_out",  want.blue,  o_m_axis_tdata[7:0]);
                check_field("green_out", want.green, o_m_axis_tdata[15:8]);
                check_field("red_out",   want.red,   o_m_axis_tdata[23:16]);
                check_field("frame_end", {7'd0, want.frame_end}, {7'd0, o_m_axis_tlast});
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: stall in phases of random density, and hold off once for a long stretch
    initial begin : out_side
        bit          hold_done;
        int unsigned span, pct;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && useful_words >= HOLD_AFTER) begin
                hold_done = 1'b1;
                @(negedge i_clk) i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                span = $urandom_range(200, 10);
                case ($urandom_range(3))
                    0:       pct = 0;
                    1:       pct = 25;
                    2:       pct = 50;
                    default: pct = 85;
                endcase
                repeat (span) @(negedge i_clk) i_m_axis_tready <= ($urandom_range(99) >= pct);
            end
        end
    end

    // Offer one word in bursts with random gaps; return at the negedge after acceptance
    task automatic send_word(input t_kind kind, input logic [23:0] pix,
                             input t_word_check check, input t_blur_pix res);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(40, 1);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= pix;
        word_check      <= check;
        word_res        <= res;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait for the block to go idle, then write both frame size registers
    task automatic set_frame_size(input logic [11:0] wv, input logic [11:0] hv);
        i_s_axis_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FRAME_WIDTH;
        i_cfg_data <= wv;
        @(negedge i_clk);
        i_cfg_idx  <= REG_FRAME_HEIGHT;
        i_cfg_data <= hv;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        size_w = wv[10:0];
        size_h = hv;
    endtask

    function automatic logic [23:0] pick_pixel();
        case ($urandom_range(9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return {$urandom_range(1) ? 8'hFF : 8'h00,
                             $urandom_range(1) ? 8'hFF : 8'h00,
                             $urandom_range(1) ? 8'hFF : 8'h00};
            default: return 24'($urandom());
        endcase
    endfunction

    // Send one whole frame, stray drain ticks inside, then drain until its last output
    task automatic run_frame(input logic [11:0] wv, input logic [11:0] hv, input bit reconfig);
        int unsigned npix;
        if (reconfig) set_frame_size(wv, hv);
        npix = eff_width() * eff_height();
        for (int unsigned n = 0; n < npix; n++) begin
            if ($urandom_range(24) == 0)
                send_word(KIND_DRAIN, 24'($urandom()), CHECK_MODEL, '0);
            send_word(KIND_PIXEL, pick_pixel(), CHECK_MODEL, '0);
        end
        // Pixels sent now are dropped but still push out pending outputs
        while (frame_open()) begin
            if ($urandom_range(9) == 0)
                send_word(KIND_PIXEL, pick_pixel(), CHECK_MODEL, '0);
            else
                send_word(KIND_DRAIN, 24'($urandom()), CHECK_MODEL, '0);
        end
        if ($urandom_range(19) == 0)
            send_word(KIND_DRAIN, 24'($urandom()), CHECK_MODEL, '0);
    endtask

    // Directed words: 1x1 frames pass the pixel through, a 3x2 frame checks edges
    t_plan_row directed_plan [21] = '{
        '{ROW_WORD, 12'd0,    12'd0, KIND_DRAIN, 24'h000000, CHECK_SILENT, 24'h0, 1'b0},
        '{ROW_CFG,  12'd1,    12'd1, KIND_PIXEL, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'h000000, CHECK_TYPED,  24'h000000, 1'b1},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'hFFFFFF, CHECK_TYPED,  24'hFFFFFF, 1'b1},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'h3CA55A, CHECK_TYPED,  24'h3CA55A, 1'b1},
        '{ROW_WORD, 12'd0,    12'd0, KIND_DRAIN, 24'hFFFFFF, CHECK_SILENT, 24'h0, 1'b0},
        '{ROW_CFG,  12'd0,    12'd0, KIND_PIXEL, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'h123456, CHECK_TYPED,  24'h123456, 1'b1},
        '{ROW_CFG,  12'h803,  12'd2, KIND_PIXEL, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_DRAIN, 24'h000000, CHECK_SILENT, 24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'hFFFFFF, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'hFFFFFF, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'hFFFFFF, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_PIXEL, 24'h00FF00, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_DRAIN, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_DRAIN, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_DRAIN, 24'h000000, CHECK_MODEL,  24'h0, 1'b0},
        '{ROW_WORD, 12'd0,    12'd0, KIND_DRAIN, 24'h000000, CHECK_SILENT, 24'h0, 1'b0}
    };

    // Main sequence
    initial begin : stimulus
        int unsigned rnd_start, pick;
        logic [11:0] wv, hv;
        bit          first;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (directed_plan[i]) begin
            if (directed_plan[i].op == ROW_CFG)
                set_frame_size(directed_plan[i].width_val, directed_plan[i].height_val);
            else
                send_word(directed_plan[i].kind, directed_plan[i].pix, directed_plan[i].check,
                          {directed_plan[i].res_pix, directed_plan[i].res_last});
        end

        // Extreme sizes: width saturated to the full line, a tall narrow frame
        run_frame(12'hFFF, 12'd1, 1'b1);
        run_frame(12'd2, 12'd100, 1'b1);

        // Random frames, mostly small, some back to back with no reconfiguration
        rnd_start = useful_words;
        first = 1'b1;
        wv = '0;
        hv = '0;
        while (useful_words - rnd_start < RANDOM_WORDS) begin
            if (first || $urandom_range(9) < 7) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    wv = 12'($urandom_range(8));
                    hv = 12'($urandom_range(6));
                end else if (pick < 90) begin
                    wv = 12'($urandom_range(40, 9));
                    hv = 12'($urandom_range(5, 1));
                end else begin
                    wv = 12'($urandom_range(160, 41));
                    hv = 12'($urandom_range(3, 1));
                end
                // Upper data bit lies outside the width register
                if ($urandom_range(3) == 0) wv = wv | 12'h800;
                run_frame(wv, hv, 1'b1);
            end else begin
                run_frame(wv, hv, 1'b0);
            end
            first = 1'b0;
        end

        // Let the last results come out, then give a verdict
        i_s_axis_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(negedge i_clk);
        repeat (2 * SETTLE) @(negedge i_clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gb3_pkg.sv
rtl/core/gb3_line_bank.sv
rtl/core/gb3_kernel.sv
rtl/core/gaussian_blur_3x3_rgb.sv
tb/testbench.sv
